[hw/rtl/bmms_pkg.sv]
// shared types and constants for the block multiply-subtract unit
package bmms_pkg;

    localparam int IDX_W  = 3;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_LOAD_C  = 2'd2,
        OP_COMPUTE = 2'd3
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FETCH  = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_ACC    = 6'b001000,
        ST_RESULT = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr;
    } mem_ctl_t;

endpackage

[hw/rtl/bmms_store.sv]
// 64 x 32 element store, one write port and one registered read port
module bmms_store
    import bmms_pkg::*;
(
    input  logic              aclk,
    input  mem_ctl_t          ctl,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= wdata;
        end
        rdata_reg <= mem[ctl.raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/block_matrix_multiply_subtract.sv]
// top level: C = C - A*B on square Q16.16 blocks with one shared multiplier
// A load request writes its store when it is accepted. A compute request runs one
// multiply-accumulate unit fed by single read ports on the A and B stores: each
// product passes through read, multiply and accumulate steps, and each C element
// then adds a floor-shift-and-saturate step and a hand-off step, the hand-off
// holding while the result side holds m_ready low.
// The block is not ready while a compute request is in progress. Order values
// above MAX_ORDER are treated as MAX_ORDER; order zero emits nothing.
module block_matrix_multiply_subtract
    import bmms_pkg::*;
#(
    parameter int MAX_ORDER = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [3:0]        cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [IDX_W-1:0]  s_row,
    input  logic [IDX_W-1:0]  s_col,
    input  logic [DATA_W-1:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [IDX_W-1:0]  m_out_row,
    output logic [IDX_W-1:0]  m_out_col,
    output logic [DATA_W-1:0] m_out_value,
    output logic              m_last
);

    localparam int ACC_W = 2 * DATA_W + $clog2(MAX_ORDER + 1);
    localparam int RES_W = ACC_W - FRAC_W + 1;
    localparam logic [3:0] MAX_N = 4'(MAX_ORDER);

    state_t state_reg, state_next;
    logic [3:0]       order_reg;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [IDX_W-1:0]  out_row_reg, out_col_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_last_reg;

    logic [3:0]       n_eff, n_m1;
    logic [IDX_W-1:0] n_top;
    logic             accept, last_k, last_i, last_j;
    logic [DATA_W-1:0] a_q, b_q, c_q;
    mem_ctl_t a_ctl, b_ctl, c_ctl;
    logic [DATA_W-1:0] c_wdata;
    logic signed [RES_W-1:0] c_ext, sh_ext, diff;
    logic [DATA_W-1:0] sat_value;
    logic              in_range;

    assign n_eff  = (order_reg > MAX_N) ? MAX_N : order_reg;
    assign n_m1   = n_eff - 4'd1;
    assign n_top  = n_m1[IDX_W-1:0];
    assign accept = s_valid && s_ready;
    assign last_k = (k_reg == n_top);
    assign last_i = (i_reg == n_top);
    assign last_j = (j_reg == n_top);

    // store ports
    always_comb begin
        a_ctl.we    = accept && (s_op == OP_LOAD_A);
        a_ctl.waddr = {s_row, s_col};
        a_ctl.raddr = {i_reg, k_reg};
        b_ctl.we    = accept && (s_op == OP_LOAD_B);
        b_ctl.waddr = {s_row, s_col};
        b_ctl.raddr = {k_reg, j_reg};
        c_ctl.raddr = {i_reg, j_reg};
        if (state_reg == ST_RESULT) begin
            c_ctl.we    = 1'b1;
            c_ctl.waddr = {i_reg, j_reg};
            c_wdata     = sat_value;
        end else begin
            c_ctl.we    = accept && (s_op == OP_LOAD_C);
            c_ctl.waddr = {s_row, s_col};
            c_wdata     = s_value;
        end
    end

    bmms_store u_a_store (.aclk(aclk), .ctl(a_ctl), .wdata(s_value), .rdata(a_q));
    bmms_store u_b_store (.aclk(aclk), .ctl(b_ctl), .wdata(s_value), .rdata(b_q));
    bmms_store u_c_store (.aclk(aclk), .ctl(c_ctl), .wdata(c_wdata), .rdata(c_q));

    // floor shift of the exact sum, subtract from c, saturate
    always_comb begin
        c_ext    = {{(RES_W-DATA_W){c_q[DATA_W-1]}}, c_q};
        sh_ext   = {acc_reg[ACC_W-1], acc_reg[ACC_W-1:FRAC_W]};
        diff     = c_ext - sh_ext;
        in_range = (diff[RES_W-1:DATA_W-1] == '0) || (diff[RES_W-1:DATA_W-1] == '1);
        if (in_range) begin
            sat_value = diff[DATA_W-1:0];
        end else if (diff[RES_W-1]) begin
            sat_value = SAT_MIN;
        end else begin
            sat_value = SAT_MAX;
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_op == OP_COMPUTE) && (n_eff != 4'd0)) begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC: begin
                acc_next = acc_reg + {{(ACC_W-2*DATA_W){prod_reg[2*DATA_W-1]}}, prod_reg};
                if (last_k) begin
                    state_next = ST_RESULT;
                end else begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_RESULT: state_next = ST_EMIT;
            ST_EMIT: begin
                if (m_ready) begin
                    k_next   = '0;
                    acc_next = '0;
                    if (last_i && last_j) begin
                        state_next = ST_IDLE;
                    end else begin
                        if (last_i) begin
                            i_next = '0;
                            j_next = j_reg + IDX_W'(1);
                        end else begin
                            i_next = i_reg + IDX_W'(1);
                        end
                        state_next = ST_FETCH;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            order_reg <= 4'd8;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                order_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        prod_reg <= (2*DATA_W)'($signed(a_q)) * (2*DATA_W)'($signed(b_q));
        if (state_reg == ST_RESULT) begin
            out_row_reg   <= i_reg;
            out_col_reg   <= j_reg;
            out_value_reg <= sat_value;
            out_last_reg  <= last_i && last_j;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_EMIT);
    assign m_out_row   = out_row_reg;
    assign m_out_col   = out_col_reg;
    assign m_out_value = out_value_reg;
    assign m_last      = out_last_reg;

endmodule

[hw/rtl/bmms_checker.sv]
// port-level checks for the block multiply-subtract unit, bound to the top level
module bmms_checker
    import bmms_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [1:0]        s_op,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_out_value,
    input logic              m_last
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value) && $stable(m_last))
        else $error("stalled result changed");

    // never takes a request while results are pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while emitting");

    // load requests produce no results
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op != OP_COMPUTE) |=> !m_valid)
        else $error("result after load request");

    // after the last element the block is ready again
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> s_ready && !m_valid)
        else $error("not idle after last element");

endmodule

bind block_matrix_multiply_subtract bmms_checker u_bmms_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_op        (s_op),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_value (m_out_value),
    .m_last      (m_last)
);
